/* design/malu_pkg.sv */
// ----------------------------------------------------------------------------
// malu_pkg
// Shared types and constants for the modular ALU.
// ----------------------------------------------------------------------------
package malu_pkg;

   localparam int unsigned FIELD_WIDTH = 32;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } opcode_type;

endpackage

/* design/malu_req_if.sv */
// ----------------------------------------------------------------------------
// malu_req_if
// Request channel: opcode and two operands, valid/ready handshake.
// ----------------------------------------------------------------------------
interface malu_req_if;
   logic                                   valid;
   logic                                   ready;
   malu_pkg::opcode_type                   opcode;
   logic [malu_pkg::FIELD_WIDTH-1:0]       operand_a;
   logic [malu_pkg::FIELD_WIDTH-1:0]       operand_b;

   modport source (output valid, output opcode, output operand_a, output operand_b,
                   input ready);
   modport sink   (input valid, input opcode, input operand_a, input operand_b,
                   output ready);
endinterface

/* design/malu_rsp_if.sv */
// ----------------------------------------------------------------------------
// malu_rsp_if
// Response channel: result and no-inverse flag, valid/ready handshake.
// ----------------------------------------------------------------------------
interface malu_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic [malu_pkg::FIELD_WIDTH-1:0]       result;
   logic                                   no_inverse;

   modport source (output valid, output result, output no_inverse, input ready);
   modport sink   (input valid, input result, input no_inverse, output ready);
endinterface

/* design/modular_alu_with_inverse.sv */
// ----------------------------------------------------------------------------
// modular_alu_with_inverse
// Modular add / subtract / multiply / divide under a configured modulus.
// ----------------------------------------------------------------------------
//
//  channel   dir   handshake          payload
//  req_chan  in    valid/ready        opcode, operand_a, operand_b
//  rsp_chan  out   valid/ready        result, no_inverse
//  csr_*     in    write enable only  csr_wdata -> modulus
//
//  Item flow: each operand is reduced by a bit-serial restoring remainder;
//  add/sub results form in the last reduction cycle. Multiply then runs
//  LSB-first double-and-add steps. Divide first runs Euclid: each round
//  doubles the divisor in align steps, then subtracts it back down; then
//  a sign-fix step and the multiply follow unless there is no inverse.
//  Every item ends with a writeback in WRITE and a return to IDLE.
//  Sequencer runs one item at a time; req ready only in IDLE.
//  Synchronous active-high reset clears control and sets modulus to 1.
//  The result register holds its transfer while rsp ready is low; a finished
//  item waits in WRITE until the register frees.
//
module modular_alu_with_inverse #(
   parameter int unsigned WIDTH = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   malu_req_if.sink                          req_chan,
   malu_rsp_if.source                        rsp_chan,
   input  logic                              csr_we,
   input  logic [malu_pkg::FIELD_WIDTH-1:0]  csr_wdata
);
   import malu_pkg::*;

   localparam int unsigned CW = $clog2(WIDTH + 1);
   localparam int unsigned SW = WIDTH + 3;   // signed Bezout coefficients

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_REDA  = 8'b0000_0010,
      ST_REDB  = 8'b0000_0100,
      ST_ALIGN = 8'b0000_1000,
      ST_SUBT  = 8'b0001_0000,
      ST_FIXS  = 8'b0010_0000,
      ST_MUL   = 8'b0100_0000,
      ST_WRITE = 8'b1000_0000
   } state_type;

   // modular add, both inputs below m
   function automatic logic [WIDTH-1:0] madd(input logic [WIDTH-1:0] x,
                                             input logic [WIDTH-1:0] y,
                                             input logic [WIDTH-1:0] m);
      logic [WIDTH:0] z;
      z = {1'b0, x} + {1'b0, y};
      if (z >= {1'b0, m}) begin
         z = z - {1'b0, m};
      end
      return z[WIDTH-1:0];
   endfunction

   state_type                state_ff, state_in;
   logic [FIELD_WIDTH-1:0]   modulus_ff;
   logic [WIDTH-1:0]         m_ff, m_in;
   opcode_type               op_ff, op_in;
   logic [CW-1:0]            cnt_ff, cnt_in;
   logic [WIDTH-1:0]         a_ff, a_in;       // operand a, later multiplicand x
   logic [WIDTH-1:0]         b_ff, b_in;       // operand b, later multiplier y
   logic [WIDTH-1:0]         sh_ff, sh_in;     // dividend bits for reduction
   logic [WIDTH-1:0]         acc_ff, acc_in;   // remainder / product accumulator
   logic [WIDTH-1:0]         r0_ff, r0_in;
   logic [WIDTH-1:0]         r1_ff, r1_in;
   logic [WIDTH-1:0]         r1sh_ff, r1sh_in;
   logic signed [SW-1:0]     s0_ff, s0_in;
   logic signed [SW-1:0]     s1_ff, s1_in;
   logic signed [SW-1:0]     s1sh_ff, s1sh_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [FIELD_WIDTH-1:0]   rsp_result_ff, rsp_result_in;
   logic                     rsp_flag_ff, rsp_flag_in;
   logic [WIDTH-1:0]         res_ff, res_in;
   logic                     flag_ff, flag_in;

   // shared datapath pieces
   logic [WIDTH:0]           red_next;
   logic [WIDTH:0]           red_sub;
   logic [WIDTH-1:0]         mul_acc;
   logic [WIDTH-1:0]         mul_x;
   logic                     r0_ge;
   logic [WIDTH-1:0]         r0_next;
   logic signed [SW-1:0]     s0_next;
   logic signed [SW-1:0]     m_signed;
   logic signed [SW-1:0]     s_fix;
   logic [WIDTH-1:0]         raw_m;
   logic                     req_xfer;

   assign req_xfer = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.result     = rsp_result_ff;
   assign rsp_chan.no_inverse = rsp_flag_ff;

   // restoring remainder step: shift in the next dividend bit
   assign red_next = {acc_ff, sh_ff[WIDTH-1]};
   assign red_sub  = red_next - {1'b0, m_ff};

   // double-and-add multiply step, LSB first
   assign mul_acc = b_ff[0] ? madd(acc_ff, a_ff, m_ff) : acc_ff;
   assign mul_x   = madd(a_ff, a_ff, m_ff);

   // Euclid subtract step
   assign r0_ge   = (r0_ff >= r1sh_ff);
   assign r0_next = r0_ge ? (r0_ff - r1sh_ff) : r0_ff;
   assign s0_next = r0_ge ? (s0_ff - s1sh_ff) : s0_ff;

   assign m_signed = $signed({3'b000, m_ff});
   assign raw_m    = WIDTH'(modulus_ff);

   always_comb begin
      s_fix = (s0_ff < 0) ? (s0_ff + m_signed) : s0_ff;
      if (s_fix >= m_signed) begin
         s_fix = s_fix - m_signed;
      end
   end

   always_comb begin
      state_in      = state_ff;
      m_in          = m_ff;
      op_in         = op_ff;
      cnt_in        = cnt_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      sh_in         = sh_ff;
      acc_in        = acc_ff;
      r0_in         = r0_ff;
      r1_in         = r1_ff;
      r1sh_in       = r1sh_ff;
      s0_in         = s0_ff;
      s1_in         = s1_ff;
      s1sh_in       = s1sh_ff;
      res_in        = res_ff;
      flag_in       = flag_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_result_in = rsp_result_ff;
      rsp_flag_in   = rsp_flag_ff;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               // zero modulus acts as one
               m_in   = (raw_m == '0) ? WIDTH'(1) : raw_m;
               op_in  = req_chan.opcode;
               sh_in  = WIDTH'(req_chan.operand_a);
               b_in   = WIDTH'(req_chan.operand_b);
               acc_in = '0;
               cnt_in = '0;
               flag_in = 1'b0;
               state_in = ST_REDA;
            end
         end
         ST_REDA, ST_REDB: begin
            acc_in = red_sub[WIDTH] ? red_next[WIDTH-1:0] : red_sub[WIDTH-1:0];
            sh_in  = {sh_ff[WIDTH-2:0], 1'b0};
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CW'(WIDTH - 1)) begin
               cnt_in = '0;
               if (state_ff == ST_REDA) begin
                  a_in     = acc_in;
                  acc_in   = '0;
                  sh_in    = b_ff;
                  state_in = ST_REDB;
               end else begin
                  b_in = acc_in;
                  unique case (op_ff)
                     OP_ADD: begin
                        res_in   = madd(a_ff, acc_in, m_ff);
                        state_in = ST_WRITE;
                     end
                     OP_SUB: begin
                        res_in   = (acc_in > a_ff) ? (a_ff + (m_ff - acc_in))
                                                   : (a_ff - acc_in);
                        state_in = ST_WRITE;
                     end
                     OP_MUL: begin
                        acc_in   = '0;
                        state_in = ST_MUL;
                     end
                     OP_DIV: begin
                        r0_in    = acc_in;
                        r1_in    = m_ff;
                        r1sh_in  = m_ff;
                        s0_in    = SW'(1);
                        s1_in    = '0;
                        s1sh_in  = '0;
                        state_in = ST_ALIGN;
                     end
                     default: state_in = ST_WRITE;
                  endcase
               end
            end
         end
         ST_ALIGN: begin
            // grow divisor by powers of two while it still fits under r0
            if (({r1sh_ff, 1'b0} <= {1'b0, r0_ff}) && (r1sh_ff != '0)) begin
               r1sh_in = {r1sh_ff[WIDTH-2:0], 1'b0};
               s1sh_in = s1sh_ff <<< 1;
               cnt_in  = cnt_ff + CW'(1);
            end else begin
               state_in = ST_SUBT;
            end
         end
         ST_SUBT: begin
            if (cnt_ff == '0) begin
               // quotient done: rotate the remainder sequence
               r0_in   = r1_ff;
               r1_in   = r0_next;
               r1sh_in = r0_next;
               s0_in   = s1_ff;
               s1_in   = s0_next;
               s1sh_in = s0_next;
               state_in = (r0_next == '0) ? ST_FIXS : ST_ALIGN;
            end else begin
               r0_in   = r0_next;
               s0_in   = s0_next;
               r1sh_in = r1sh_ff >> 1;
               s1sh_in = s1sh_ff >>> 1;
               cnt_in  = cnt_ff - CW'(1);
            end
         end
         ST_FIXS: begin
            if ((r0_ff != WIDTH'(1)) && (m_ff != WIDTH'(1))) begin
               res_in   = '0;
               flag_in  = 1'b1;
               state_in = ST_WRITE;
            end else begin
               b_in     = s_fix[WIDTH-1:0];
               acc_in   = '0;
               cnt_in   = '0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            acc_in = mul_acc;
            a_in   = mul_x;
            b_in   = b_ff >> 1;
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CW'(WIDTH - 1)) begin
               res_in   = mul_acc;
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_result_in = FIELD_WIDTH'(res_ff);
               rsp_flag_in   = flag_ff;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         modulus_ff   <= FIELD_WIDTH'(1);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            modulus_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      m_ff          <= m_in;
      op_ff         <= op_in;
      cnt_ff        <= cnt_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      sh_ff         <= sh_in;
      acc_ff        <= acc_in;
      r0_ff         <= r0_in;
      r1_ff         <= r1_in;
      r1sh_ff       <= r1sh_in;
      s0_ff         <= s0_in;
      s1_ff         <= s1_in;
      s1sh_ff       <= s1sh_in;
      res_ff        <= res_in;
      flag_ff       <= flag_in;
      rsp_result_ff <= rsp_result_in;
      rsp_flag_ff   <= rsp_flag_in;
   end

endmodule
